[src/qsnc_pkg.sv]
// shared types and constants for the qualified sql name checker
// character classes, queue item layout, scanner phases; no dependencies
package qsnc_pkg;

  localparam int unsigned QSNC_QUEUE_DEPTH = 4;
  localparam int unsigned QSNC_CH_W        = 8;
  localparam int unsigned QSNC_OUT_W       = 8;

  localparam logic [QSNC_CH_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [QSNC_CH_W-1:0] CH_DOLLAR     = 8'h24;
  localparam logic [QSNC_CH_W-1:0] CH_HASH       = 8'h23;
  localparam logic [QSNC_CH_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [QSNC_CH_W-1:0] CH_DQUOTE     = 8'h22;
  localparam logic [QSNC_CH_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [QSNC_CH_W-1:0] CH_ZERO       = 8'h00;

  typedef enum logic [2:0] {
    CC_SPACE = 3'd0,
    CC_QUOTE = 3'd1,
    CC_DOT   = 3'd2,
    CC_START = 3'd3,
    CC_CONT  = 3'd4,
    CC_ZERO  = 3'd5,
    CC_OTHER = 3'd6
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic        last;
    logic        empty_end;
  } item_t;

  typedef enum logic [2:0] {
    PH_EXPECT = 3'd0,
    PH_UNQ    = 3'd1,
    PH_INQ    = 3'd2,
    PH_QPEND  = 3'd3,
    PH_AFTER  = 3'd4
  } phase_e;

  function automatic char_class_e classify(input logic [QSNC_CH_W-1:0] c);
    char_class_e cls;
    if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
      cls = CC_SPACE;
    end else if (c == CH_DQUOTE) begin
      cls = CC_QUOTE;
    end else if (c == CH_DOT) begin
      cls = CC_DOT;
    end else if (c == CH_UNDERSCORE || c[7] || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h41 && c <= 8'h5A)) begin
      cls = CC_START;
    end else if ((c >= 8'h30 && c <= 8'h39) || c == CH_DOLLAR || c == CH_HASH) begin
      cls = CC_CONT;
    end else if (c == CH_ZERO) begin
      cls = CC_ZERO;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

endpackage

[src/qsnc_front.sv]
// front end: accepts input words and classifies each byte
// uses qsnc_pkg; feeds qsnc_queue
module qsnc_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [qsnc_pkg::QSNC_CH_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output qsnc_pkg::item_t               item_o
);
  import qsnc_pkg::*;

  assign s_axis_tready_o = ~q_full_i;
  assign push_o          = s_axis_tvalid_i & ~q_full_i;

  always_comb begin
    item_o.cls       = classify(s_axis_tdata_i);
    item_o.last      = s_axis_tlast_i;
    item_o.empty_end = s_axis_tuser_i;
  end

endmodule

[src/qsnc_queue.sv]
// short fifo of classified words between front and back end
// uses qsnc_pkg item_t
module qsnc_queue #(
  parameter int unsigned Depth = qsnc_pkg::QSNC_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qsnc_pkg::item_t item_i,
  input  logic            pop_i,
  output qsnc_pkg::item_t item_o,
  output logic            valid_o,
  output logic            full_o
);
  import qsnc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntFull);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/qsnc_back.sv]
// back end: identifier-chain scanner and output register
// uses qsnc_pkg; drains qsnc_queue
module qsnc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qsnc_pkg::item_t                 item_i,
  input  logic                            item_valid_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [qsnc_pkg::QSNC_OUT_W-1:0] m_axis_tdata_o
);
  import qsnc_pkg::*;

  phase_e phase_q, phase_d;
  logic   has_content_q, has_content_d;
  logic   fail_q, fail_d;
  logic   out_valid_q, out_valid_d;
  logic   out_res_q, out_res_d;
  logic   ends, out_free;

  // part finished: space waits, dot opens the next part
  function automatic phase_e after_part(input char_class_e cls, output logic bad);
    phase_e ph;
    bad = 1'b0;
    ph  = PH_AFTER;
    if (cls == CC_SPACE) begin
      ph = PH_AFTER;
    end else if (cls == CC_DOT) begin
      ph = PH_EXPECT;
    end else begin
      bad = 1'b1;
    end
    return ph;
  endfunction

  assign ends     = item_i.last | item_i.empty_end;
  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign pop_o    = item_valid_i & (~ends | out_free);

  always_comb begin
    logic   bad;
    phase_e ph;
    logic   hc;
    logic   fl;
    bad           = 1'b0;
    ph            = phase_q;
    hc            = has_content_q;
    fl            = fail_q;
    phase_d       = phase_q;
    has_content_d = has_content_q;
    fail_d        = fail_q;
    out_valid_d   = out_valid_q & ~m_axis_tready_i;
    out_res_d     = out_res_q;

    if (!fail_q) begin
      case (phase_q)
        PH_EXPECT: begin
          if (item_i.cls == CC_SPACE) begin
            ph = PH_EXPECT;
          end else if (item_i.cls == CC_QUOTE) begin
            hc = 1'b0;
            ph = PH_INQ;
          end else if (item_i.cls == CC_START) begin
            ph = PH_UNQ;
          end else begin
            fl = 1'b1;
          end
        end
        PH_UNQ: begin
          if (item_i.cls != CC_START && item_i.cls != CC_CONT) begin
            ph = after_part(item_i.cls, bad);
            fl = bad;
          end
        end
        PH_INQ: begin
          if (item_i.cls == CC_ZERO) begin
            fl = 1'b1;
          end else if (item_i.cls == CC_QUOTE) begin
            ph = PH_QPEND;
          end else begin
            hc = 1'b1;
          end
        end
        PH_QPEND: begin
          if (item_i.cls == CC_QUOTE) begin
            // doubled quote is content
            hc = 1'b1;
            ph = PH_INQ;
          end else if (!has_content_q) begin
            fl = 1'b1;
          end else begin
            ph = after_part(item_i.cls, bad);
            fl = bad;
          end
        end
        PH_AFTER: begin
          ph = after_part(item_i.cls, bad);
          fl = bad;
        end
        default: begin
          fl = 1'b1;
        end
      endcase
    end

    if (pop_o) begin
      if (ends) begin
        out_valid_d   = 1'b1;
        out_res_d     = ~item_i.empty_end & ~fl &
                        ((ph == PH_UNQ) || (ph == PH_AFTER) || ((ph == PH_QPEND) && hc));
        phase_d       = PH_EXPECT;
        has_content_d = 1'b0;
        fail_d        = 1'b0;
      end else begin
        phase_d       = ph;
        has_content_d = hc;
        fail_d        = fl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_EXPECT;
      has_content_q <= 1'b0;
      fail_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      has_content_q <= has_content_d;
      fail_q        <= fail_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(QSNC_OUT_W-1){1'b0}}, out_res_q};

endmodule

[src/qualified_sql_name_checker_core.sv]
// Qualified sql name checker, top level.
// Input stream: one byte per word on s_axis; tlast ends a string, tuser marks
// a word with no byte that ends a null or empty string.
// Output stream: one word per string on m_axis, tdata[0] = 1 when the string
// is a dot-separated chain of plain or double-quoted identifiers.
// A word is taken every cycle while the queue has room. The front end
// classifies each byte and writes it into a QueueDepth-entry fifo; the back
// end runs the scanner at one word per cycle while words are queued and loads
// the result register. The last word of a string is stored in the fifo, and
// its result then in the result register. When m_axis stalls, the back end
// keeps scanning words up to the next string end and holds that end in the
// queue until the result register frees up; s_axis drops tready only when the
// fifo fills. Reset empties the fifo, clears the result valid flag and puts
// the scanner back at the start of a string.
module qualified_sql_name_checker_core #(
  parameter int unsigned QueueDepth = qsnc_pkg::QSNC_QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [qsnc_pkg::QSNC_CH_W-1:0]  s_axis_tdata_i,  // [7:0] ch
  input  logic                            s_axis_tlast_i,  // last
  input  logic                            s_axis_tuser_i,  // empty_end
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [qsnc_pkg::QSNC_OUT_W-1:0] m_axis_tdata_o   // [0] valid_res, rest zero
);
  import qsnc_pkg::*;

  item_t front_item, back_item;
  logic  push, pop, q_full, q_valid;

  qsnc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (front_item)
  );

  qsnc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  qsnc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (back_item),
    .item_valid_i    (q_valid),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[src/qsnc_checker.sv]
// port-level checks for the qualified sql name checker
// uses qsnc_pkg; bound to qualified_sql_name_checker_core
module qsnc_checker #(
  parameter int unsigned QueueDepth = qsnc_pkg::QSNC_QUEUE_DEPTH
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [qsnc_pkg::QSNC_OUT_W-1:0] m_axis_tdata_o
);
  import qsnc_pkg::*;

  localparam int unsigned PendW = $clog2(QueueDepth + 2);
  localparam logic [PendW-1:0] PendMax = PendW'(QueueDepth + 1);

  logic [PendW-1:0] pend_q, pend_d;
  logic             in_end, out_take;

  // string ends taken in but whose result word has not left yet
  assign in_end   = s_axis_tvalid_i & s_axis_tready_o & (s_axis_tlast_i | s_axis_tuser_i);
  assign out_take = m_axis_tvalid_o & m_axis_tready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_end && !out_take) begin
      pend_d = pend_q + 1'b1;
    end else if (out_take && !in_end) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[QSNC_OUT_W-1:1] == '0)
    else $error("result padding bits not zero");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != '0)
    else $error("result word without a string end");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendMax)
    else $error("more string ends in flight than storage allows");

endmodule

bind qualified_sql_name_checker_core qsnc_checker #(
  .QueueDepth (QueueDepth)
) u_qsnc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
